>>> rtl/sorted_list_insert_remove_defines.svh
// ----------------------------------------------------------------------------
// sorted list assertion macros
// shared concurrent assertion forms for the sorted list block
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_REMOVE_DEFINES_SVH
`define SORTED_LIST_INSERT_REMOVE_DEFINES_SVH

// property that must hold at every edge outside reset
`define SLI_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sli_pkg.sv
// ----------------------------------------------------------------------------
// sorted list package
// shared widths, codes and types of the sorted list block
// ----------------------------------------------------------------------------
package sli_pkg;

	localparam int DATA_W       = 32;
	localparam int COUNT_W      = 5;
	localparam int CAPACITY_DEF = 16;
	localparam int TDATA_OUT_W  = 40;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_REMOVE = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_DONE      = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_NOT_FOUND = 2'd2
	} status_t;

	// update command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic rm;
	} cell_cmd_t;

endpackage

>>> rtl/sli_cell.sv
// ----------------------------------------------------------------------------
// sorted list cell
// one entry of the list: compares against the request and shifts with neighbors
// ----------------------------------------------------------------------------
module sli_cell (
	input  logic              clk,
	input  sli_pkg::cell_cmd_t cmd,
	input  sli_pkg::data_t    value,
	input  logic              occupied,
	input  sli_pkg::data_t    left_entry,
	input  logic              left_lt,
	input  sli_pkg::data_t    right_entry,
	output sli_pkg::data_t    entry_q,
	output sli_pkg::data_t    entry_d,
	output logic              lt,
	output logic              hit
);
	import sli_pkg::*;

	logic at_pos;

	assign lt     = occupied && (entry_q < value);
	// first cell that is not smaller than the request
	assign at_pos = !lt && left_lt;
	assign hit    = at_pos && occupied && (entry_q == value);

	always_comb begin
		entry_d = entry_q;
		if (cmd.ins && !lt) begin
			entry_d = left_lt ? value : left_entry;
		end else if (cmd.rm && !lt) begin
			entry_d = right_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

>>> rtl/sorted_list_insert_remove.sv
// ----------------------------------------------------------------------------
// sorted list with insert and remove
// ascending list of signed values kept in a row of shifting cells
// ----------------------------------------------------------------------------
// usage:
//   requests enter on the s_ side: s_tuser carries the mode (insert or
//   remove), s_tdata the signed value. every request gives one result on
//   the m_ side with status, count after the request and smallest entry.
//   all cells compare against the request in parallel and shift by one
//   place toward or away from the tail in the same cycle. the result is
//   in the output register the next cycle and one request per cycle is
//   accepted.
//   the output register is the only buffer: while a result waits and
//   m_tready is low, s_tready is low too. with m_tready high the block
//   takes a request every cycle.
//   reset empties the list (count zero); cell contents are left as they
//   are and are only read below the count.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove #(
	parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [sli_pkg::DATA_W-1:0]         s_tdata,  // [31:0] value
	input  logic [0:0]                         s_tuser,  // [0] mode
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [1:0] status, [6:2] count, [38:7] smallest, [39] zero
	output logic [sli_pkg::TDATA_OUT_W-1:0]    m_tdata
);
	import sli_pkg::*;

	`include "sorted_list_insert_remove_defines.svh"

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	logic [CNT_W-1:0] count_q, count_d;
	logic             fire, is_insert, is_remove, not_full, found;
	data_t            value;
	cell_cmd_t        cmd;
	status_t          status_d;
	data_t            smallest_d;

	data_t            entry_q [CAPACITY];
	data_t            entry_d [CAPACITY];
	logic [CAPACITY-1:0] lt, hit;

	logic             out_valid_q;
	status_t          status_q;
	logic [COUNT_W-1:0] count_out_q;
	data_t            smallest_q;

	assign value     = data_t'(s_tdata);
	assign s_tready  = !out_valid_q || m_tready;
	assign fire      = s_tvalid && s_tready;
	assign is_insert = (mode_t'(s_tuser[0]) == MODE_INSERT);
	assign is_remove = (mode_t'(s_tuser[0]) == MODE_REMOVE);
	assign not_full  = count_q < CAP_CNT;
	assign found     = |hit;

	assign cmd.ins = fire && is_insert && not_full;
	assign cmd.rm  = fire && is_remove && found;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			data_t left_entry, right_entry;
			logic  left_lt;
			if (i == 0) begin : g_head
				assign left_entry = value;
				assign left_lt    = 1'b1;
			end else begin : g_body
				assign left_entry = entry_q[i-1];
				assign left_lt    = lt[i-1];
			end
			if (i == CAPACITY - 1) begin : g_tail
				assign right_entry = entry_q[i];
			end else begin : g_mid
				assign right_entry = entry_q[i+1];
			end
			sli_cell u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.value       (value),
				.occupied    (CNT_W'(i) < count_q),
				.left_entry  (left_entry),
				.left_lt     (left_lt),
				.right_entry (right_entry),
				.entry_q     (entry_q[i]),
				.entry_d     (entry_d[i]),
				.lt          (lt[i]),
				.hit         (hit[i])
			);
		end
	endgenerate

	always_comb begin
		count_d  = count_q;
		status_d = STATUS_DONE;
		if (is_insert) begin
			if (not_full) begin
				count_d = count_q + CNT_ONE;
			end else begin
				status_d = STATUS_FULL;
			end
		end else begin
			if (found) begin
				count_d = count_q - CNT_ONE;
			end else begin
				status_d = STATUS_NOT_FOUND;
			end
		end
		smallest_d = (count_d != '0) ? entry_d[0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q <= count_d;
			end
			if (s_tready) begin
				out_valid_q <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q    <= status_d;
			count_out_q <= COUNT_W'(count_d);
			smallest_q  <= smallest_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, smallest_q, count_out_q, status_q};

	`SLI_ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q <= CAP_CNT, "count above capacity")
	`SLI_ASSERT_NEXT(a_insert_grows, clk, arst_n, cmd.ins, count_q == $past(count_q) + CNT_ONE, "insert did not grow count")
	`SLI_ASSERT_NEXT(a_remove_shrinks, clk, arst_n, cmd.rm, count_q == $past(count_q) - CNT_ONE, "remove did not shrink count")
	`SLI_ASSERT_NEXT(a_result_follows, clk, arst_n, fire, m_tvalid, "accepted request gave no result")

endmodule

>>> sim/sorted_list_checker.sv
// ----------------------------------------------------------------------------
// sorted list result checker
// watches both stream sides, keeps its own ascending list and compares each
// result with the one predicted for the oldest open request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_list_checker #(
	parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [sli_pkg::DATA_W-1:0]      s_tdata,   // [31:0] value
	input  logic [0:0]                      s_tuser,   // [0] mode
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// [1:0] status, [6:2] count, [38:7] smallest, [39] zero
	input  logic [sli_pkg::TDATA_OUT_W-1:0] m_tdata,
	output int                              mismatches,
	output int                              outstanding
);
	import sli_pkg::*;

	typedef struct {
		status_t              status;
		logic [COUNT_W-1:0]   count;
		data_t                smallest;
	} list_result_t;

	data_t        sorted_vals [CAPACITY];
	int           stored_count;
	int           result_idx;
	list_result_t results_q [$];

	// applies one request to the local list and returns the result it gives
	function automatic list_result_t apply_request(mode_t op, data_t v);
		list_result_t r;
		int           pos;
		int           n;
		int           i;
		n = stored_count;
		pos = 0;
		r.status = STATUS_DONE;
		if (op == MODE_INSERT) begin
			if (n >= CAPACITY) begin
				r.status = STATUS_FULL;
			end else begin
				// new duplicate goes in front of the equal entries
				while (pos < n && sorted_vals[pos] < v)
					pos++;
				for (i = n; i > pos; i--)
					sorted_vals[i] = sorted_vals[i-1];
				sorted_vals[pos] = v;
				n++;
			end
		end else begin
			while (pos < n && sorted_vals[pos] < v)
				pos++;
			if (pos < n && sorted_vals[pos] == v) begin
				for (i = pos; i + 1 < n; i++)
					sorted_vals[i] = sorted_vals[i+1];
				n--;
			end else begin
				r.status = STATUS_NOT_FOUND;
			end
		end
		stored_count = n;
		r.count = COUNT_W'(n);
		r.smallest = (n != 0) ? sorted_vals[0] : '0;
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("%0t ns: result %0d %s: got %0h, expected %0h",
			$realtime, result_idx, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		list_result_t want;
		if (!arst_n) begin
			stored_count = 0;
			result_idx = 0;
			mismatches = 0;
			results_q.delete();
		end else begin
			// result first: a request taken at this edge answers no earlier than the next
			if (m_tvalid && m_tready) begin
				if (results_q.size() == 0) begin
					report_mismatch("result with no open request", 64'(m_tdata), '0);
				end else begin
					want = results_q.pop_front();
					if (m_tdata[1:0] !== want.status)
						report_mismatch("status", 64'(m_tdata[1:0]), 64'(want.status));
					if (m_tdata[6:2] !== want.count)
						report_mismatch("count", 64'(m_tdata[6:2]), 64'(want.count));
					if (m_tdata[38:7] !== want.smallest)
						report_mismatch("smallest", 64'(m_tdata[38:7]),
							64'(unsigned'(want.smallest)));
					if (m_tdata[39] !== 1'b0)
						report_mismatch("pad bit", 64'(m_tdata[39]), '0);
				end
				result_idx++;
			end
			if (s_tvalid && s_tready)
				results_q.push_back(apply_request(mode_t'(s_tuser[0]), data_t'(s_tdata)));
		end
		outstanding <= results_q.size();
	end

endmodule

>>> sim/tb_sorted_list_insert_remove.sv
// ----------------------------------------------------------------------------
// sorted list testbench
// directed inserts and removes around the extremes, a full and an empty list,
// then random grow and shrink phases with idle gaps on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_list_insert_remove;
	import sli_pkg::*;

	localparam int    CAPACITY = CAPACITY_DEF;
	localparam int    ITEMS    = 1550;
	localparam data_t VAL_MIN  = 32'sh8000_0000;
	localparam data_t VAL_MAX  = 32'sh7fff_ffff;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [DATA_W-1:0]      s_tdata;   // [31:0] value
	logic [0:0]             s_tuser;   // [0] mode
	logic                   m_tvalid;
	logic                   m_tready;
	// [1:0] status, [6:2] count, [38:7] smallest, [39] zero
	logic [TDATA_OUT_W-1:0] m_tdata;

	int    mismatches;
	int    outstanding;
	bit    tx_idle_on;
	bit    rx_idle_on;
	bit    hold_req;
	data_t held [$];

	sorted_list_insert_remove #(
		.CAPACITY (CAPACITY)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	sorted_list_checker #(
		.CAPACITY (CAPACITY)
	) u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// small values give duplicates, a few extremes, the rest full range
	function automatic data_t pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return data_t'(int'($urandom_range(0, 16)) - 8);
		if (r == 4) begin
			case ($urandom_range(0, 3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return '0;
				default: return '1;
			endcase
		end
		return data_t'($urandom);
	endfunction

	task automatic send_request(mode_t op, data_t v);
		int gap;
		int i;
		gap = tx_idle_on ? idle_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// track what the list holds, for choosing removes that hit
		if (op == MODE_INSERT) begin
			if (held.size() < CAPACITY)
				held.push_back(v);
		end else begin
			for (i = 0; i < held.size(); i++) begin
				if (held[i] == v) begin
					held.delete(i);
					break;
				end
			end
		end
	endtask

	// sender stops until every open request has answered or the limit is reached
	task automatic wait_drain(int limit);
		int n;
		n = 0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 && n < limit) begin
			@(posedge clk);
			n++;
		end
	endtask

	// receiver
	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				// long hold so the output register fills and the input stalls
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			stall = rx_idle_on ? idle_len() : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// stimulus
	initial begin
		bit    grow;
		mode_t op;
		data_t v;
		int    k;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		hold_req   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(MODE_REMOVE, 32'sd5);     // remove on empty list
		send_request(MODE_INSERT, VAL_MAX);
		send_request(MODE_INSERT, VAL_MIN);
		send_request(MODE_INSERT, '0);
		send_request(MODE_INSERT, '1);
		send_request(MODE_INSERT, '0);         // duplicate
		send_request(MODE_REMOVE, '0);
		send_request(MODE_REMOVE, 32'sd123);   // absent, between stored values
		send_request(MODE_REMOVE, VAL_MIN);    // smallest goes
		for (k = 0; k < 13; k++)
			send_request(MODE_INSERT, data_t'(int'(k % 5) - 2));
		send_request(MODE_INSERT, 32'sd77);    // list full
		send_request(MODE_REMOVE, 32'sd99);    // absent on full list
		send_request(MODE_REMOVE, VAL_MAX);

		grow = 1'b1;
		for (k = 0; k < ITEMS; k++) begin
			if (k % 200 == 0) begin
				tx_idle_on = ($urandom_range(0, 3) != 0);
				rx_idle_on = ($urandom_range(0, 3) != 0);
			end
			if (k == 400) begin
				tx_idle_on = 1'b0;
				hold_req   = 1'b1;
			end
			if (k == 800 || k == 1200)
				wait_drain(100_000);
			if (held.size() == CAPACITY && $urandom_range(0, 3) == 0)
				grow = 1'b0;
			if (held.size() == 0 && $urandom_range(0, 3) == 0)
				grow = 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				// noise
				op = mode_t'($urandom_range(0, 1));
				v  = data_t'($urandom);
			end else begin
				op = ($urandom_range(0, 3) != 0) ^ grow ? MODE_REMOVE : MODE_INSERT;
				if (op == MODE_REMOVE && held.size() != 0 && $urandom_range(0, 9) < 8)
					v = held[$urandom_range(0, held.size() - 1)];
				else
					v = pick_value();
			end
			send_request(op, v);
		end

		wait_drain(100_000);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
